### hw/rtl/ypo_pkg.sv
// ypo_pkg: shared types, fixed-point formats, matrix coefficients and helpers
// for the YIQ pulse overlay pixel pipeline. No dependencies.
`timescale 1ns / 1ps

package ypo_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;

  // Internal signed width: values held in [-8, 8).
  localparam int W  = FRAC_BITS + 4;
  // Wide sum width for matrix products.
  localparam int SW = 2 * FRAC_BITS + 8;
  // Coefficient width (magnitude below 2.0).
  localparam int CW = FRAC_BITS + 2;
  // Unsigned 0..ONE width (scaled byte, quotient, clamped channel).
  localparam int UW = FRAC_BITS + 1;

  // Byte scaling: floor(x / 255) done as (x * SM) >> SK, exact for x < 2^(F+9).
  localparam int     XW = FRAC_BITS + 9;
  localparam int     SK = FRAC_BITS + 17;
  localparam int     MW = FRAC_BITS + 10;
  localparam longint SM = ((longint'(1) << SK) + 254) / 255;
  localparam int     PW = XW + MW;

  // Pulse alignment from Q1.14.
  localparam int PSH_L = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
  localparam int PSH_R = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;

  // Normalizing divider: quotient bits resolved per stage.
  localparam int DSTEP = 3;
  localparam int DS    = (UW + DSTEP - 1) / DSTEP;
  localparam int RW    = FRAC_BITS + 4;

  localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (FRAC_BITS + 3)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(1 << (FRAC_BITS + 3));
  localparam logic signed [SW-1:0] HALF   = SW'(1 << (FRAC_BITS - 1));
  localparam logic signed [W-1:0]  ONE_W  = W'(ONE);

  // NTSC matrices, round-half-away of milli * 2^F / 1000, row-major.
  localparam logic signed [CW-1:0] YIQ_COEF [9] = '{
     CW'((299 * ONE + 500) / 1000),  CW'((587 * ONE + 500) / 1000),
     CW'((114 * ONE + 500) / 1000),
     CW'((596 * ONE + 500) / 1000), -CW'((274 * ONE + 500) / 1000),
    -CW'((322 * ONE + 500) / 1000),
     CW'((211 * ONE + 500) / 1000), -CW'((523 * ONE + 500) / 1000),
     CW'((312 * ONE + 500) / 1000)
  };

  localparam logic signed [CW-1:0] RGB_COEF [9] = '{
     CW'(ONE),  CW'((956 * ONE + 500) / 1000),   CW'((621 * ONE + 500) / 1000),
     CW'(ONE), -CW'((272 * ONE + 500) / 1000),  -CW'((647 * ONE + 500) / 1000),
     CW'(ONE), -CW'((1106 * ONE + 500) / 1000),  CW'((1703 * ONE + 500) / 1000)
  };

  typedef struct packed {
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic signed [15:0] pulse_luma;
    logic signed [15:0] pulse_inphase;
    logic signed [15:0] pulse_quadrature;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  function automatic logic signed [W-1:0] sat_int(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    begin
      t = v;
      if (v > SAT_HI) t = SAT_HI;
      else if (v < SAT_LO) t = SAT_LO;
      return W'(t);
    end
  endfunction

  // floor((s + 2^(F-1)) / 2^F), then saturate
  function automatic logic signed [W-1:0] rnd_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    begin
      t = (s + HALF) >>> FRAC_BITS;
      return sat_int(t);
    end
  endfunction

endpackage

### hw/rtl/yiq_pulse_overlay_pixel.sv
// yiq_pulse_overlay_pixel: pipelined RGB -> YIQ, pulse add, YIQ -> RGB,
// max normalize, clamp and byte conversion. Depends on ypo_pkg.
`timescale 1ns / 1ps

// Channel | Dir | Handshake            | Beat payload
// in      | in  | in_valid / in_ready  | ypo_pkg::pix_in_t  (RGB bytes, YIQ pulse Q1.14)
// out     | out | out_valid / out_ready| ypo_pkg::pix_out_t (RGB bytes)
//
// One beat per cycle sustained while out_ready is high; 8 + DS register stages, so a
// beat passes from stage 0 through each of them to the output register. The depth is
// set by the normalizing divider, which resolves 3 quotient bits per stage.
// Each stage holds its own valid bit and loads when empty or when the stage after
// it moves, so a stalled output lets bubbles fill and nothing is lost or repeated.
// rst (synchronous) clears the valid bits only; payload registers are not reset.

module yiq_pulse_overlay_pixel (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ypo_pkg::pix_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ypo_pkg::pix_out_t out_data
);

  localparam int F  = ypo_pkg::FRAC_BITS;
  localparam int W  = ypo_pkg::W;
  localparam int SW = ypo_pkg::SW;
  localparam int UW = ypo_pkg::UW;
  localparam int RW = ypo_pkg::RW;
  localparam int DS = ypo_pkg::DS;
  localparam int DSTEP = ypo_pkg::DSTEP;

  // Stage map: 0 scale, 1 fwd products, 2 fwd sum, 3 pulse add,
  // 4 inv products, 5 inv sum, 6 max, 7..7+DS-1 divider, last output.
  localparam int ST_DIV0 = 7;
  localparam int NS      = ST_DIV0 + DS + 1;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  // Ready chain: a stage may load when empty or when its successor moves.
  always_comb begin
    en[NS-1] = !vld[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // ---------------- stage 0: byte * 2^F / 255 reciprocal product, pulse align
  logic [ypo_pkg::PW-1:0]  prod0 [3];
  logic signed [SW-1:0]    pul0  [3];
  logic [7:0]              byte_in [3];
  logic signed [15:0]      pulse_in [3];

  assign byte_in[0]  = in_data.red_in;
  assign byte_in[1]  = in_data.green_in;
  assign byte_in[2]  = in_data.blue_in;
  assign pulse_in[0] = in_data.pulse_luma;
  assign pulse_in[1] = in_data.pulse_inphase;
  assign pulse_in[2] = in_data.pulse_quadrature;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        prod0[k] <= ypo_pkg::PW'(({ {(ypo_pkg::XW-8-F){1'b0}}, byte_in[k], {F{1'b0}} }
                    + ypo_pkg::XW'(127))) * ypo_pkg::PW'(ypo_pkg::SM);
        pul0[k]  <= (SW'(pulse_in[k]) <<< ypo_pkg::PSH_L) >>> ypo_pkg::PSH_R;
      end
    end
  end

  // ---------------- stage 1: forward matrix products
  logic signed [SW-1:0] mp1  [9];
  logic signed [SW-1:0] pul1 [3];
  logic [UW-1:0]        sc   [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sc[k] = prod0[k][ypo_pkg::SK +: UW];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mp1[3*r+c] <= SW'(ypo_pkg::YIQ_COEF[3*r+c]) * SW'(signed'({1'b0, sc[c]}));
        end
      end
      pul1 <= pul0;
    end
  end

  // ---------------- stage 2: forward sums
  logic signed [W-1:0]  yiq2 [3];
  logic signed [SW-1:0] pul2 [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int r = 0; r < 3; r++) begin
        yiq2[r] <= ypo_pkg::rnd_sat(mp1[3*r] + mp1[3*r+1] + mp1[3*r+2]);
      end
      pul2 <= pul1;
    end
  end

  // ---------------- stage 3: pulse add
  logic signed [W-1:0] yiq3 [3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int r = 0; r < 3; r++) begin
        yiq3[r] <= ypo_pkg::sat_int(SW'(yiq2[r]) + pul2[r]);
      end
    end
  end

  // ---------------- stage 4: inverse matrix products
  logic signed [SW-1:0] mp4 [9];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mp4[3*r+c] <= SW'(ypo_pkg::RGB_COEF[3*r+c]) * SW'(yiq3[c]);
        end
      end
    end
  end

  // ---------------- stage 5: inverse sums
  logic signed [W-1:0] rgb5 [3];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int r = 0; r < 3; r++) begin
        rgb5[r] <= ypo_pkg::rnd_sat(mp4[3*r] + mp4[3*r+1] + mp4[3*r+2]);
      end
    end
  end

  // ---------------- stage 6: channel max, normalize flag
  logic signed [W-1:0] rgb6 [3];
  logic signed [W-1:0] mx6;
  logic                nrm6;
  logic signed [W-1:0] mx_c;

  always_comb begin
    mx_c = rgb5[0];
    if (rgb5[1] > mx_c) mx_c = rgb5[1];
    if (rgb5[2] > mx_c) mx_c = rgb5[2];
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      rgb6 <= rgb5;
      mx6  <= mx_c;
      nrm6 <= (mx_c > ypo_pkg::ONE_W);
    end
  end

  // ---------------- divider: floor(c * 2^F / m), valid for 0 < c <= m
  logic [RW-1:0]       drem [DS][3];
  logic [UW-1:0]       dquo [DS][3];
  logic [RW-2:0]       dm   [DS];
  logic signed [W-1:0] dc   [DS][3];
  logic                dn   [DS];

  genvar d;
  generate
    for (d = 0; d < DS; d++) begin : g_div
      logic [RW-1:0]       rem_in [3];
      logic [UW-1:0]       quo_in [3];
      logic [RW-2:0]       m_in;
      logic signed [W-1:0] c_in   [3];
      logic                n_in;
      logic [RW-1:0]       rem_nx [3];
      logic [UW-1:0]       quo_nx [3];

      if (d == 0) begin : g_first
        always_comb begin
          for (int k = 0; k < 3; k++) begin
            rem_in[k] = {1'b0, rgb6[k][RW-2:0]};
            quo_in[k] = '0;
            c_in[k]   = rgb6[k];
          end
          m_in = mx6[RW-2:0];
          n_in = nrm6;
        end
      end else begin : g_next
        always_comb begin
          rem_in = drem[d-1];
          quo_in = dquo[d-1];
          c_in   = dc[d-1];
          m_in   = dm[d-1];
          n_in   = dn[d-1];
        end
      end

      always_comb begin
        rem_nx = rem_in;
        quo_nx = quo_in;
        for (int j = 0; j < DSTEP; j++) begin
          if (d * DSTEP + j < UW) begin
            for (int k = 0; k < 3; k++) begin
              if (rem_nx[k] >= {1'b0, m_in}) begin
                quo_nx[k] = {quo_nx[k][UW-2:0], 1'b1};
                rem_nx[k] = (rem_nx[k] - {1'b0, m_in}) << 1;
              end else begin
                quo_nx[k] = {quo_nx[k][UW-2:0], 1'b0};
                rem_nx[k] = rem_nx[k] << 1;
              end
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en[ST_DIV0+d]) begin
          drem[d] <= rem_nx;
          dquo[d] <= quo_nx;
          dc[d]   <= c_in;
          dm[d]   <= m_in;
          dn[d]   <= n_in;
        end
      end
    end
  endgenerate

  // ---------------- output: select, clamp to 0..ONE, * 255 >> F
  logic [UW-1:0]   chv  [3];
  logic [UW+7:0]   scl  [3];
  logic [7:0]      byte_o [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dn[DS-1]) begin
        chv[k] = (dc[DS-1][k] > 0) ? dquo[DS-1][k] : '0;
      end else if (dc[DS-1][k] < 0) begin
        chv[k] = '0;
      end else if (dc[DS-1][k] > ypo_pkg::ONE_W) begin
        chv[k] = UW'(ypo_pkg::ONE);
      end else begin
        chv[k] = dc[DS-1][k][UW-1:0];
      end
      scl[k]    = {chv[k], 8'b0} - (UW+8)'(chv[k]);
      byte_o[k] = scl[k][F +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_data.red_out   <= byte_o[0];
      out_data.green_out <= byte_o[1];
      out_data.blue_out  <= byte_o[2];
    end
  end

  // ---------------- checks
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    (vld[NS-2] && dn[DS-1] && dc[DS-1][0] > 0) |-> (dquo[DS-1][0] <= UW'(ypo_pkg::ONE)))
    else $error("normalize quotient above one");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
